// File: sv/sia_pkg.sv
// Package with the opcode type for the signed integer ALU.
`default_nettype none
package sia_pkg;
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;
endpackage
`default_nettype wire

// File: sv/sia_if.sv
// Valid/ready channel interfaces for ALU requests and results.
`default_nettype none
interface sia_req_if #(parameter int WIDTH = 8);
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic signed [WIDTH-1:0] operand_a;
  logic signed [WIDTH-1:0] operand_b;
  modport source (output valid, opcode, operand_a, operand_b, input ready);
  modport sink (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface sia_rsp_if #(parameter int WIDTH = 8);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] result;
  logic signed [WIDTH-1:0] remainder;
  logic                    divide_by_zero;
  modport source (output valid, result, remainder, divide_by_zero, input ready);
  modport sink (input valid, result, remainder, divide_by_zero, output ready);
endinterface
`default_nettype wire

// File: sv/signed_int8_alu_core.sv
// Signed ALU: add, subtract, Booth multiply low word and restoring divide.
//
// One request channel (opcode, operand_a, operand_b) and one result channel
// (result, remainder, divide_by_zero), both valid/ready.
// The datapath is a pipeline of WIDTH+2 register stages: a front stage that
// forms magnitudes and the add/subtract result, then WIDTH stages that each
// retire one Booth multiplier bit and one restoring divide step, then a
// sign-fix stage that also serves as the output register.
// Throughput is one request per cycle while the receiver does not stall, set
// by one subtract-and-compare per stage.
// The whole pipeline advances whenever the output register is empty or being
// taken, so a stalled receiver holds every stage in place and nothing is lost
// or repeated; bubbles inside the pipeline are never squeezed out.
// Synchronous reset clears all valid bits; the first request may be accepted
// in the cycle after reset is released.
`default_nettype none
module signed_int8_alu_core #(
  parameter int WIDTH = 8
) (
  input wire logic clk,
  input wire logic rst,
  sia_req_if.sink   req,
  sia_rsp_if.source rsp
);
  import sia_pkg::*;

  localparam int N = WIDTH;

  typedef struct packed {
    logic [1:0]       op;
    logic [WIDTH-1:0] m;      // multiplicand
    logic [WIDTH-1:0] q;      // multiplier bits
    logic             prev;   // Booth trailing bit
    logic [WIDTH-1:0] acc;    // product or add/sub result
    logic [WIDTH-1:0] n;      // dividend magnitude, shifted left
    logic [WIDTH-1:0] d;      // divisor magnitude
    logic [WIDTH:0]   rem;
    logic [WIDTH-1:0] quo;
    logic             na;
    logic             nb;
    logic             dz;
  } stage_t;

  stage_t          st [0:N];
  logic [N:0]      vld;
  logic            adv;

  logic [WIDTH-1:0] out_res;
  logic [WIDTH-1:0] out_rem;
  logic             out_dz;
  logic             out_vld;

  assign adv       = !out_vld || rsp.ready;
  assign req.ready = adv;

  // Front stage.
  stage_t s0;
  always_comb begin
    s0      = '0;
    s0.op   = req.opcode;
    s0.m    = req.operand_a;
    s0.q    = req.operand_b;
    s0.na   = req.operand_a[WIDTH-1];
    s0.nb   = req.operand_b[WIDTH-1];
    s0.n    = s0.na ? (~req.operand_a + 1'b1) : req.operand_a;
    s0.d    = s0.nb ? (~req.operand_b + 1'b1) : req.operand_b;
    s0.dz   = (req.operand_b == '0);
    case (req.opcode)
      OP_ADD:  s0.acc = req.operand_a + req.operand_b;
      OP_SUB:  s0.acc = req.operand_a - req.operand_b;
      default: s0.acc = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (adv) vld[0] <= req.valid;
    if (adv) st[0] <= s0;
  end

  // Iteration stages: step i handles multiplier bit i and dividend bit N-1-i.
  for (genvar i = 0; i < N; i++) begin : g_step
    stage_t nx;
    logic [WIDTH:0] sh;
    logic [WIDTH-1:0] term;
    always_comb begin
      nx   = st[i];
      term = st[i].m << i;
      if (st[i].op == OP_MUL) begin
        if (st[i].q[i] && !st[i].prev) nx.acc = st[i].acc - term;
        else if (!st[i].q[i] && st[i].prev) nx.acc = st[i].acc + term;
      end
      nx.prev = st[i].q[i];
      sh      = {st[i].rem[WIDTH-1:0], st[i].n[WIDTH-1]};
      nx.n    = st[i].n << 1;
      if (sh >= {1'b0, st[i].d}) begin
        nx.rem = sh - {1'b0, st[i].d};
        nx.quo = {st[i].quo[WIDTH-2:0], 1'b1};
      end else begin
        nx.rem = sh;
        nx.quo = {st[i].quo[WIDTH-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else if (adv) vld[i+1] <= vld[i];
      if (adv) st[i+1] <= nx;
    end
  end

  // Sign fix and output register.
  logic [WIDTH-1:0] f_res, f_rem;
  logic             f_dz;
  always_comb begin
    f_res = st[N].acc;
    f_rem = '0;
    f_dz  = 1'b0;
    if (st[N].op == OP_DIV) begin
      if (st[N].dz) begin
        f_res = '0;
        f_dz  = 1'b1;
      end else begin
        f_res = (st[N].na != st[N].nb) ? (~st[N].quo + 1'b1) : st[N].quo;
        f_rem = st[N].na ? (~st[N].rem[WIDTH-1:0] + 1'b1) : st[N].rem[WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (adv) out_vld <= vld[N];
    if (adv) begin
      out_res <= f_res;
      out_rem <= f_rem;
      out_dz  <= f_dz;
    end
  end

  assign rsp.valid          = out_vld;
  assign rsp.result         = out_res;
  assign rsp.remainder      = out_rem;
  assign rsp.divide_by_zero = out_dz;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_vld && !rsp.ready |=> out_vld && $stable(out_res) && $stable(out_rem))
    else $error("result changed under stall");
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_dz |-> out_res == '0 && out_rem == '0)
    else $error("divide by zero result not zero");
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved under stall");
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the signed ALU core: directed and random requests.
`default_nettype none
module tb_top;
  import sia_pkg::*;

  localparam int WIDTH = 8;
  localparam int LATENCY = WIDTH + 2;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [WIDTH-1:0] result;
    logic signed [WIDTH-1:0] remainder;
    logic                    divide_by_zero;
  } alu_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sia_req_if #(.WIDTH(WIDTH)) req ();
  sia_rsp_if #(.WIDTH(WIDTH)) rsp ();

  signed_int8_alu_core #(.WIDTH(WIDTH)) dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  alu_out_t expected_q[$];
  int mismatch_count = 0;
  int result_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int op_seen[4];
  int dz_seen = 0;

  // Golden arithmetic in plain terms: wrap to WIDTH, truncating division.
  function automatic alu_out_t alu_predict(opcode_t op, logic signed [WIDTH-1:0] a,
                                           logic signed [WIDTH-1:0] b);
    alu_out_t o;
    logic [WIDTH:0] mag_a, mag_b, quo, rmd;
    logic signed [2*WIDTH-1:0] prod;
    o = '0;
    case (op)
      OP_ADD: o.result = a + b;
      OP_SUB: o.result = a - b;
      OP_MUL: begin
        prod = (2*WIDTH)'(a) * (2*WIDTH)'(b);
        o.result = prod[WIDTH-1:0];
      end
      default: begin
        if (b == 0) begin
          o.divide_by_zero = 1'b1;
        end else begin
          mag_a = a[WIDTH-1] ? -{a[WIDTH-1], a} : {1'b0, a};
          mag_b = b[WIDTH-1] ? -{b[WIDTH-1], b} : {1'b0, b};
          quo = mag_a / mag_b;
          rmd = mag_a % mag_b;
          o.result = (a[WIDTH-1] != b[WIDTH-1]) ? -quo[WIDTH-1:0] : quo[WIDTH-1:0];
          o.remainder = a[WIDTH-1] ? -rmd[WIDTH-1:0] : rmd[WIDTH-1:0];
        end
      end
    endcase
    return o;
  endfunction

  initial begin
    req.valid = 1'b0;
    req.opcode = '0;
    req.operand_a = '0;
    req.operand_b = '0;
    rsp.ready = 1'b0;
  end

  // Receiver side: random stalls, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (rst || hold_off)
      rsp.ready <= 1'b0;
    else
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    alu_out_t got, exp_out;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.result, rsp.remainder, rsp.divide_by_zero};
      result_count++;
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result %0d rem %0d dz %0d", got.result, got.remainder,
                   got.divide_by_zero);
      end else begin
        exp_out = expected_q.pop_front();
        if (got !== exp_out) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result mismatch: expected %0d rem %0d dz %0d, got %0d rem %0d dz %0d",
                     exp_out.result, exp_out.remainder, exp_out.divide_by_zero,
                     got.result, got.remainder, got.divide_by_zero);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results still pending", expected_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Valid stays high after an accepted request until the next call or drain
  // decides what the next cycle carries.
  task automatic send_request(opcode_t op, logic signed [WIDTH-1:0] a,
                              logic signed [WIDTH-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= op;
    req.operand_a <= a;
    req.operand_b <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_q.push_back(alu_predict(op, a, b));
    op_seen[op]++;
    if (op == OP_DIV && b == 0) dz_seen++;
    @(negedge clk);
  endtask

  task automatic drain;
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed;
    logic signed [WIDTH-1:0] edges[6];
    edges = '{-128, -1, 0, 1, 127, 2};
    for (int op = 0; op < 4; op++) begin
      send_request(opcode_t'(op), 127, 1);
      send_request(opcode_t'(op), -128, -1);
      send_request(opcode_t'(op), -128, 127);
      send_request(opcode_t'(op), 127, -128);
    end
    send_request(OP_DIV, 57, 0);
    send_request(OP_DIV, -128, 0);
    send_request(OP_DIV, -7, 2);
    send_request(OP_DIV, 7, -2);
    send_request(OP_DIV, -128, -128);
    send_request(OP_MUL, -1, -1);
    send_request(OP_ADD, -1, -1);
    for (int i = 0; i < 2; i++) send_request(OP_SUB, edges[i], edges[5 - i]);
    drain();
  endtask

  function automatic logic signed [WIDTH-1:0] pick_operand();
    logic signed [WIDTH-1:0] v;
    case ($urandom_range(7))
      0: v = 0;
      1: v = -128;
      2: v = 127;
      3: v = -1;
      default: v = WIDTH'($urandom);
    endcase
    return v;
  endfunction

  task automatic test_random(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < count; i++)
      send_request(opcode_t'($urandom_range(3)), pick_operand(), pick_operand());
    send_idle_pct = 0;
    drain();
  endtask

  // Receiver holds off while the sender keeps pushing, so the pipeline backs up.
  task automatic test_backpressure;
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 60; i++)
        send_request(opcode_t'($urandom_range(3)), pick_operand(), pick_operand());
    join
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(500, 0, 0);
    test_random(500, 83, 0);
    test_random(500, 0, 83);
    test_random(500, 35, 35);
    test_backpressure();
    recv_stall_pct = 0;
    $display("covered %0d results: add %0d, sub %0d, mul %0d, div %0d (%0d by zero)",
             result_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3], dz_seen);
    $display("idling phases none/sender/receiver/both and a long receiver hold-off");
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d left over", mismatch_count, expected_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
